// ----- src/itoa_pkg.sv -----
package itoa_pkg;

  localparam int RadixBits  = 6;
  localparam int CharBits   = 7;
  localparam int DigitSplit = 10;

  localparam logic [RadixBits-1:0] RadixMin = 6'd2;
  localparam logic [RadixBits-1:0] RadixMax = 6'd36;

  localparam logic [CharBits-1:0] AsciiZero  = 7'h30;
  localparam logic [CharBits-1:0] AsciiUpperA = 7'h41;
  localparam logic [CharBits-1:0] AsciiMinus = 7'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [CharBits-1:0] digit_code(input logic [RadixBits-1:0] d);
    logic [CharBits-1:0] dw;
    dw = {1'b0, d};
    if (dw < CharBits'(DigitSplit)) begin
      return AsciiZero + dw;
    end
    return AsciiUpperA + (dw - CharBits'(DigitSplit));
  endfunction

endpackage

// ----- src/itoa_if.sv -----
interface itoa_in_if #(
  parameter int VALUE_BITS = 33
);
  logic                             valid;
  logic                             ready;
  logic signed [VALUE_BITS-1:0]     value;
  logic [itoa_pkg::RadixBits-1:0]   radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itoa_out_if;
  logic                           valid;
  logic                           ready;
  logic [itoa_pkg::CharBits-1:0]  character;
  logic                           last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- src/itoa_div.sv -----
// Restoring divider, one quotient bit per cycle. Divisor is at most 36,
// so the partial remainder fits the radix width.
module itoa_div #(
  parameter int VALUE_BITS = 33
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VALUE_BITS-1:0]             dividend_i,
  input  logic [itoa_pkg::RadixBits-1:0]    divisor_i,
  output itoa_pkg::div_status_t             status_o,
  output logic [VALUE_BITS-1:0]             quotient_o,
  output logic [itoa_pkg::RadixBits-1:0]    remainder_o
);

  localparam int RW = itoa_pkg::RadixBits;
  localparam int CntW = $clog2(VALUE_BITS);

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic [VALUE_BITS-1:0] shift_q;
  logic [RW-1:0]         rem_q, dvs_q;

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_d;

  assign trial = {rem_q, shift_q[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(VALUE_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else if (busy_q) begin
      shift_q <= {shift_q[VALUE_BITS-2:0], ge};
      rem_q   <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = shift_q;
  assign remainder_o   = rem_q;

endmodule

// ----- src/itoa_stack.sv -----
// Digit store: digits land least significant first and are read back
// from the top down. Registered read.
module itoa_stack #(
  parameter int DEPTH = 33,
  parameter int WIDTH = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/integer_to_ascii_any_base.sv -----
// Signed integer to ASCII text in radix 2..36.
// in_i carries one beat per number: value (VALUE_BITS, two's complement) and
// radix (radix 0..1 acts as 2, 37..63 as 36). out_o emits one beat per
// character, most significant first: '-' for a negative value, then digits
// '0'..'9', 'A'..'Z'; last marks the final character. Zero gives "0".
// The single text longer than VALUE_BITS characters (most negative value,
// radix 2) is cut to VALUE_BITS characters; the dropped digit is its final '0'.
// Digits come from one shared restoring divider, one quotient bit per cycle,
// and each finished digit fills a digit stack. The stack is then read back
// top down, each digit through a fetch state and then a load state; a '-'
// goes out from a sign state between the two phases.
// in_i.ready is high only between numbers; the last character may still sit
// in the output register when the next number is taken.
// A stalled receiver holds the output register and the sequencer waits in
// its sign and load states.
// Reset clears the sequencer, the output valid and the divider status;
// nothing else needs it.
module integer_to_ascii_any_base #(
  parameter int VALUE_BITS = 33
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if.sink     in_i,
  itoa_out_if.source  out_o
);

  localparam int RW = itoa_pkg::RadixBits;
  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  itoa_pkg::state_e state_q, state_d;

  logic          neg_q, neg_d;
  logic [RW-1:0] radix_q, radix_d;
  logic [CW-1:0] nd_q, nd_d;
  logic [CW-1:0] left_q, left_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;

  logic                         out_valid_q;
  logic [itoa_pkg::CharBits-1:0] char_q, char_d;
  logic                         last_q, last_d;
  logic                         load_out;
  logic                         slot_free;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RW-1:0]         div_divisor;
  itoa_pkg::div_status_t div_st;
  logic [VALUE_BITS-1:0] div_quo;
  logic [RW-1:0]         div_rem;

  logic          stk_we;
  logic [RW-1:0] stk_rdata;

  logic [VALUE_BITS-1:0] in_bits;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [RW-1:0]         in_radix;
  logic [CW:0]           total;

  assign in_bits = in_i.value;
  assign in_neg  = in_bits[VALUE_BITS-1];
  assign in_mag  = in_neg ? (~in_bits + 1'b1) : in_bits;

  always_comb begin
    if (in_i.radix < itoa_pkg::RadixMin) begin
      in_radix = itoa_pkg::RadixMin;
    end else if (in_i.radix > itoa_pkg::RadixMax) begin
      in_radix = itoa_pkg::RadixMax;
    end else begin
      in_radix = in_i.radix;
    end
  end

  // sign plus digits, counting the digit being finished now
  assign total = (CW+1)'(nd_q) + (CW+1)'(1) + (CW+1)'(neg_q);

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == itoa_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    radix_d      = radix_q;
    nd_d         = nd_q;
    left_d       = left_q;
    rd_ptr_d     = rd_ptr_q;
    div_start    = 1'b0;
    div_dividend = div_quo;
    div_divisor  = radix_q;
    stk_we       = 1'b0;
    load_out     = 1'b0;
    char_d       = char_q;
    last_d       = last_q;

    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          div_start    = 1'b1;
          div_dividend = in_mag;
          div_divisor  = in_radix;
          neg_d        = in_neg;
          radix_d      = in_radix;
          nd_d         = '0;
          state_d      = itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_DIV: begin
        if (div_st.done) begin
          stk_we = 1'b1;
          nd_d   = nd_q + 1'b1;
          if (div_quo == '0) begin
            left_d   = (total > (CW+1)'(VALUE_BITS)) ? CW'(VALUE_BITS) : total[CW-1:0];
            rd_ptr_d = nd_q[AW-1:0];
            state_d  = itoa_pkg::ST_SIGN;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (!neg_q) begin
          state_d = itoa_pkg::ST_FETCH;
        end else if (slot_free) begin
          load_out = 1'b1;
          char_d   = itoa_pkg::AsciiMinus;
          last_d   = (left_q == CW'(1));
          left_d   = left_q - 1'b1;
          state_d  = itoa_pkg::ST_FETCH;
        end
      end
      itoa_pkg::ST_FETCH: begin
        state_d = itoa_pkg::ST_LOAD;
      end
      itoa_pkg::ST_LOAD: begin
        if (slot_free) begin
          load_out = 1'b1;
          char_d   = itoa_pkg::digit_code(stk_rdata);
          last_d   = (left_q == CW'(1));
          left_d   = left_q - 1'b1;
          rd_ptr_d = rd_ptr_q - 1'b1;
          state_d  = (left_q == CW'(1)) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_FETCH;
        end
      end
      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    radix_q  <= radix_d;
    nd_q     <= nd_d;
    left_q   <= left_d;
    rd_ptr_q <= rd_ptr_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  itoa_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_st),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  itoa_stack #(
    .DEPTH(VALUE_BITS),
    .WIDTH(RW)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(nd_q[AW-1:0]),
    .wdata_i(div_rem),
    .raddr_i(rd_ptr_q),
    .rdata_o(stk_rdata)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == itoa_pkg::ST_DIV))
    else $error("divider finished outside digit phase");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_pkg::ST_DIV) |-> (nd_q < CW'(VALUE_BITS)))
    else $error("digit stack overflow");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (!in_i.ready && div_st.busy))
    else $error("divider not started on accepted beat");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !load_out)
    else $error("character emitted while dividing");

endmodule
